>>> rtl/lspc_pkg.sv
// lspc_pkg: shared types and constants of the laser scan polyline classifier
// no dependencies
`default_nettype none
package lspc_pkg;
   localparam logic [2:0] REG_POSE_X = 3'd0;
   localparam logic [2:0] REG_POSE_Y = 3'd1;
   localparam logic [2:0] REG_HEADING = 3'd2;
   localparam logic [2:0] REG_FIRST_ANGLE = 3'd3;
   localparam logic [2:0] REG_ANGLE_STEP = 3'd4;
   localparam logic [2:0] REG_MAX_RANGE = 3'd5;
   localparam logic [2:0] REG_MAX_DIST = 3'd6;

   localparam logic [1:0] KIND_FIRST = 2'd0;
   localparam logic [1:0] KIND_OBSTACLE = 2'd1;
   localparam logic [1:0] KIND_MYSTERY = 2'd2;
   localparam logic [1:0] KIND_FREE = 2'd3;

   localparam logic signed [31:0] KINV_Q30 = 32'sd652032874;
   localparam int ATAN_COUNT = 24;

   typedef struct packed {
      logic signed [30:0] pose_x;
      logic signed [30:0] pose_y;
      logic [15:0] heading;
      logic [15:0] first_angle;
      logic [15:0] angle_step;
      logic [15:0] max_range;
      logic [15:0] max_dist;
   } cfg_type;

   // classified work for the back end
   typedef struct packed {
      logic [15:0] angle;
      logic [15:0] rc;
      logic first;
      logic last;
      logic valid;
      logic skipped;
   } job_type;

   function automatic logic [31:0] atan_turn32(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0: v = 32'h20000000; 5'd1: v = 32'h12E4051E; 5'd2: v = 32'h09FB385B;
         5'd3: v = 32'h051111D4; 5'd4: v = 32'h028B0D43; 5'd5: v = 32'h0145D7E1;
         5'd6: v = 32'h00A2F61E; 5'd7: v = 32'h00517C55; 5'd8: v = 32'h0028BE53;
         5'd9: v = 32'h00145F2F; 5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518; 5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146; 5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

>>> rtl/lspc_stream_if.sv
// lspc_in_if / lspc_out_if / lspc_csr_if: valid-ready channels
// no dependencies
`default_nettype none
interface lspc_in_if;
   logic valid;
   logic ready;
   logic [15:0] range_sample;
   logic first_beam;
   logic last_beam;
   modport source(output valid, range_sample, first_beam, last_beam, input ready);
   modport sink(input valid, range_sample, first_beam, last_beam, output ready);
endinterface

interface lspc_out_if;
   logic valid;
   logic ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic [1:0] edge_kind;
   logic scan_end;
   modport source(output valid, point_x, point_y, edge_kind, scan_end, input ready);
   modport sink(input valid, point_x, point_y, edge_kind, scan_end, output ready);
endinterface

interface lspc_csr_if;
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [31:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/lspc_front.sv
// lspc_front: beam angle tracking, validity and drop decisions
// depends on lspc_pkg
`default_nettype none
module lspc_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire lspc_pkg::cfg_type cfg,
   input  wire logic in_valid,
   output logic in_ready,
   input  wire logic [15:0] range_sample,
   input  wire logic first_beam,
   input  wire logic last_beam,
   output logic job_valid,
   input  wire logic job_ready,
   output lspc_pkg::job_type job
);
   logic [15:0] beam_angle_ff, beam_angle_in;
   logic skipping_ff;
   logic valid_r;
   logic fire;
   lspc_pkg::job_type q_ff [2];
   logic [1:0] count_ff;
   logic wr_ff, rd_ff;

   assign in_ready = (count_ff != 2'd2);
   assign fire = in_valid && in_ready;
   assign beam_angle_in = first_beam ? cfg.first_angle : beam_angle_ff + cfg.angle_step;
   assign valid_r = (range_sample != 16'd0) && (range_sample <= cfg.max_range);
   wire emit = valid_r || first_beam || last_beam;
   assign job_valid = (count_ff != 2'd0);
   assign job = q_ff[rd_ff];
   wire push = fire && emit;
   wire pop = job_valid && job_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_angle_ff <= 16'd0;
         skipping_ff <= 1'b0;
         count_ff <= 2'd0;
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         if (fire) begin
            beam_angle_ff <= beam_angle_in;
            skipping_ff <= !emit;
         end
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         q_ff[wr_ff].angle <= cfg.heading + beam_angle_in;
         q_ff[wr_ff].rc <= (range_sample < cfg.max_range) ? range_sample : cfg.max_range;
         q_ff[wr_ff].first <= first_beam;
         q_ff[wr_ff].last <= last_beam;
         q_ff[wr_ff].valid <= valid_r;
         q_ff[wr_ff].skipped <= skipping_ff;
      end
   end
endmodule
`default_nettype wire

>>> rtl/lspc_back.sv
// lspc_back: iterative cordic, pose offset, edge classification, output register
// depends on lspc_pkg
`default_nettype none
module lspc_back #(
   parameter int CORDIC_STEPS = 16,
   parameter int ANGLE_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire lspc_pkg::cfg_type cfg,
   input  wire logic job_valid,
   output logic job_ready,
   input  wire lspc_pkg::job_type job,
   output logic out_valid,
   input  wire logic out_ready,
   output logic signed [31:0] point_x,
   output logic signed [31:0] point_y,
   output logic [1:0] edge_kind,
   output logic scan_end
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL = 3'd1;
   localparam logic [2:0] S_ROT = 3'd2;
   localparam logic [2:0] S_POSE = 3'd3;
   localparam logic [2:0] S_DIFF = 3'd4;
   localparam logic [2:0] S_SQ = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;
   localparam int SB = $clog2(CORDIC_STEPS + 1);
   localparam int XW = 52;
   localparam int ZW = ANGLE_BITS + 2;

   logic [2:0] state_ff;
   lspc_pkg::job_type j_ff;
   logic signed [XW-1:0] x_ff, y_ff;
   logic signed [ZW-1:0] z_ff;
   logic [SB-1:0] i_ff;
   logic flip_ff;
   logic signed [31:0] px_ff, py_ff, prev_x_ff, prev_y_ff;
   logic prev_valid_ff;
   logic [16:0] ax_ff, ay_ff;
   logic big_ff;
   logic [33:0] sq_ff;
   logic [31:0] md2_ff;

   assign job_ready = (state_ff == S_IDLE);

   logic [ANGLE_BITS-1:0] a_sc;
   assign a_sc = ANGLE_BITS'({job.angle, {ANGLE_BITS{1'b0}}} >> 16);
   wire [1:0] quad = a_sc[ANGLE_BITS-1 -: 2];
   wire q_flip = (quad == 2'b01) || (quad == 2'b10);
   wire signed [ZW-1:0] z0 = q_flip ?
      $signed({2'b00, a_sc}) - $signed(ZW'(1) <<< (ANGLE_BITS-1)) :
      (quad == 2'b11 ? $signed({2'b00, a_sc}) - $signed(ZW'(1) <<< ANGLE_BITS)
                     : $signed({2'b00, a_sc}));

   wire [32:0] t_raw = {1'b0, lspc_pkg::atan_turn32(5'(i_ff))}
                       + (33'd1 << (31 - ANGLE_BITS));
   wire signed [ZW-1:0] t_i = $signed(ZW'(t_raw >> (32 - ANGLE_BITS)));
   wire signed [XW-1:0] dx = y_ff >>> i_ff;
   wire signed [XW-1:0] dy = x_ff >>> i_ff;
   wire signed [XW-1:0] xr = (flip_ff ? -x_ff : x_ff) + (XW'(1) <<< 29);
   wire signed [XW-1:0] yr = (flip_ff ? -y_ff : y_ff) + (XW'(1) <<< 29);
   wire signed [33:0] sx = 34'(xr >>> 30) + 34'(cfg.pose_x);
   wire signed [33:0] sy = 34'(yr >>> 30) + 34'(cfg.pose_y);

   function automatic logic signed [31:0] sat(input logic signed [33:0] v);
      if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -34'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   wire signed [32:0] ddx = 33'(px_ff) - 33'(prev_x_ff);
   wire signed [32:0] ddy = 33'(py_ff) - 33'(prev_y_ff);
   wire [32:0] adx = ddx[32] ? 33'(-ddx) : 33'(ddx);
   wire [32:0] ady = ddy[32] ? 33'(-ddy) : 33'(ddy);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid <= 1'b0;
         prev_x_ff <= 32'sd0;
         prev_y_ff <= 32'sd0;
         prev_valid_ff <= 1'b0;
      end else begin
         if (out_valid && out_ready && (state_ff != S_DONE)) out_valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid && job_ready) begin
                  j_ff <= job;
                  z_ff <= z0;
                  flip_ff <= q_flip;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               x_ff <= XW'($signed({1'b0, j_ff.rc})) * XW'(lspc_pkg::KINV_Q30);
               y_ff <= '0;
               i_ff <= '0;
               state_ff <= S_ROT;
            end
            S_ROT: begin
               if (32'(i_ff) == CORDIC_STEPS || 32'(i_ff) == lspc_pkg::ATAN_COUNT) begin
                  state_ff <= S_POSE;
               end else begin
                  if (!z_ff[ZW-1]) begin
                     x_ff <= x_ff - dx; y_ff <= y_ff + dy; z_ff <= z_ff - t_i;
                  end else begin
                     x_ff <= x_ff + dx; y_ff <= y_ff - dy; z_ff <= z_ff + t_i;
                  end
                  i_ff <= i_ff + 1'b1;
               end
            end
            S_POSE: begin
               px_ff <= sat(sx);
               py_ff <= sat(sy);
               state_ff <= S_DIFF;
            end
            S_DIFF: begin
               big_ff <= (adx > 33'd65535) || (ady > 33'd65535);
               ax_ff <= adx[16:0];
               ay_ff <= ady[16:0];
               md2_ff <= cfg.max_dist * cfg.max_dist;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               sq_ff <= 34'(ax_ff) * 34'(ax_ff) + 34'(ay_ff) * 34'(ay_ff);
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!out_valid || out_ready) begin
                  point_x <= px_ff;
                  point_y <= py_ff;
                  scan_end <= j_ff.last;
                  if (j_ff.first) edge_kind <= lspc_pkg::KIND_FIRST;
                  else if (prev_valid_ff && j_ff.valid && !j_ff.skipped)
                     edge_kind <= (!big_ff && sq_ff <= 34'(md2_ff)) ?
                        lspc_pkg::KIND_OBSTACLE : lspc_pkg::KIND_MYSTERY;
                  else edge_kind <= lspc_pkg::KIND_FREE;
                  prev_x_ff <= px_ff;
                  prev_y_ff <= py_ff;
                  prev_valid_ff <= j_ff.valid;
                  out_valid <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> rtl/laser_scan_polyline_classifier_unit.sv
// laser_scan_polyline_classifier_unit: top level, register file and the two halves
// depends on lspc_pkg, lspc_stream_if, lspc_front, lspc_back
//
// req channel: one range sample a word with first and last beam marks.
// rsp channel: one world point a word with the edge kind to the previous
// point and a scan end mark; dropped samples give no word.
// csr channel: register writes by index, always ready; write only when idle.
// the front end tracks the beam angle and queues up to two jobs; the back
// end runs one iterative cordic step per cycle, and each point passes in turn
// through the scale, rotate, pose, difference, square and done states.
// dropped samples are taken by the front end and never reach the back end.
// a stalled rsp holds its word; the back end finishes the next point and
// waits, then the queue fills and req_ready drops.
// synchronous reset returns registers to defaults and empties the queue.
`default_nettype none
module laser_scan_polyline_classifier_unit #(
   parameter int CORDIC_STEPS = 16,
   parameter int ANGLE_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   lspc_in_if.sink req,
   lspc_out_if.source rsp,
   lspc_csr_if.sink csr
);
   lspc_pkg::cfg_type cfg_ff;
   logic job_valid, job_ready;
   lspc_pkg::job_type job;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pose_x <= 31'sd0;
         cfg_ff.pose_y <= 31'sd0;
         cfg_ff.heading <= 16'd0;
         cfg_ff.first_angle <= 16'd0;
         cfg_ff.angle_step <= 16'd182;
         cfg_ff.max_range <= 16'd30000;
         cfg_ff.max_dist <= 16'd500;
      end else if (csr.valid) begin
         case (csr.index)
            lspc_pkg::REG_POSE_X: cfg_ff.pose_x <= csr.data[30:0];
            lspc_pkg::REG_POSE_Y: cfg_ff.pose_y <= csr.data[30:0];
            lspc_pkg::REG_HEADING: cfg_ff.heading <= csr.data[15:0];
            lspc_pkg::REG_FIRST_ANGLE: cfg_ff.first_angle <= csr.data[15:0];
            lspc_pkg::REG_ANGLE_STEP: cfg_ff.angle_step <= csr.data[15:0];
            lspc_pkg::REG_MAX_RANGE: cfg_ff.max_range <= csr.data[15:0];
            lspc_pkg::REG_MAX_DIST: cfg_ff.max_dist <= csr.data[15:0];
            default: ;
         endcase
      end
   end

   lspc_front u_front (
      .clock, .reset, .cfg(cfg_ff),
      .in_valid(req.valid), .in_ready(req.ready),
      .range_sample(req.range_sample), .first_beam(req.first_beam),
      .last_beam(req.last_beam),
      .job_valid, .job_ready, .job
   );

   lspc_back #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_back (
      .clock, .reset, .cfg(cfg_ff),
      .job_valid, .job_ready, .job,
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .point_x(rsp.point_x), .point_y(rsp.point_y),
      .edge_kind(rsp.edge_kind), .scan_end(rsp.scan_end)
   );
endmodule
`default_nettype wire

>>> rtl/lspc_checker.sv
// lspc_checker: port level assertions, bound to the top level
// depends on laser_scan_polyline_classifier_unit
`default_nettype none
module lspc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [1:0] rsp_edge_kind,
   input wire logic rsp_scan_end,
   input wire logic [31:0] rsp_point_x,
   input wire logic csr_ready
);
   // output word holds while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point_x)
         && $stable(rsp_edge_kind))
      else $error("rsp word changed under stall");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");
   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_point_x, rsp_edge_kind, rsp_scan_end}))
      else $error("rsp word has unknown bits");
   a_csr: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr not ready");
endmodule

bind laser_scan_polyline_classifier_unit lspc_checker u_chk (
   .clock, .reset, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_edge_kind(rsp.edge_kind), .rsp_scan_end(rsp.scan_end),
   .rsp_point_x(rsp.point_x), .csr_ready(csr.ready)
);
`default_nettype wire
